>>> rtl/mdsg_pkg.sv
`timescale 1ns / 1ps
package mdsg_pkg;

    localparam int STEP_COUNT_BITS_DEF = 24;
    localparam int MAX_SUBSTEPS_DEF    = 4;
    localparam int AXES                = 4;
    localparam int AXIS_W              = $clog2(AXES);
    localparam int POS_W               = 32;
    localparam int GALVO_OUT_W         = 16;

    localparam logic [POS_W-1:0] GALVO_LIMIT = 32'h0000FEFF;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_SET_POS = 2'd2;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    function automatic logic [GALVO_OUT_W-1:0] galvo_clamp(input logic [POS_W-1:0] g);
        logic [GALVO_OUT_W-1:0] res;
        if (g > GALVO_LIMIT) begin
            res = GALVO_LIMIT[GALVO_OUT_W-1:0];
        end else begin
            res = g[GALVO_OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/mdsg_if.sv
`timescale 1ns / 1ps
interface mdsg_in_if #(
    parameter int STEP_W = mdsg_pkg::STEP_COUNT_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [1:0]                     op;
    logic [STEP_W-1:0]              steps_x;
    logic [STEP_W-1:0]              steps_y;
    logic [STEP_W-1:0]              steps_z;
    logic [STEP_W-1:0]              steps_aux;
    logic [STEP_W-1:0]              event_total;
    logic [3:0]                     dir_mask;
    logic [2:0]                     loops_per_tick;
    logic                           z_min_active;
    logic                           z_max_active;
    logic [1:0]                     axis_index;
    logic signed [mdsg_pkg::POS_W-1:0] position_value;

    modport source (
        output valid, op, steps_x, steps_y, steps_z, steps_aux, event_total,
               dir_mask, loops_per_tick, z_min_active, z_max_active,
               axis_index, position_value,
        input  ready
    );
    modport sink (
        input  valid, op, steps_x, steps_y, steps_z, steps_aux, event_total,
               dir_mask, loops_per_tick, z_min_active, z_max_active,
               axis_index, position_value,
        output ready
    );
endinterface

interface mdsg_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [3:0]                              step_pulses;
    logic [3:0]                              dir_out;
    logic signed [mdsg_pkg::POS_W-1:0]       pos_x;
    logic signed [mdsg_pkg::POS_W-1:0]       pos_y;
    logic signed [mdsg_pkg::POS_W-1:0]       pos_z;
    logic signed [mdsg_pkg::POS_W-1:0]       pos_fourth;
    logic [mdsg_pkg::GALVO_OUT_W-1:0]        galvo_x;
    logic [mdsg_pkg::GALVO_OUT_W-1:0]        galvo_y;
    logic                                    z_endstop_hit;
    logic                                    block_done;
    logic                                    idle;
    logic                                    last;

    modport source (
        output valid, step_pulses, dir_out, pos_x, pos_y, pos_z, pos_fourth,
               galvo_x, galvo_y, z_endstop_hit, block_done, idle, last,
        input  ready
    );
    modport sink (
        input  valid, step_pulses, dir_out, pos_x, pos_y, pos_z, pos_fourth,
               galvo_x, galvo_y, z_endstop_hit, block_done, idle, last,
        output ready
    );
endinterface

>>> rtl/mdsg_axis_alu.sv
`timescale 1ns / 1ps
module mdsg_axis_alu #(
    parameter int STEP_W = mdsg_pkg::STEP_COUNT_BITS_DEF,
    parameter int ACC_W  = STEP_W + 2
) (
    input  logic [ACC_W-1:0]           i_acc,
    input  logic [STEP_W-1:0]          i_steps,
    input  logic [STEP_W-1:0]          i_total,
    input  logic                       i_dir,
    input  logic [mdsg_pkg::POS_W-1:0] i_pos,
    input  logic [mdsg_pkg::POS_W-1:0] i_galvo,
    output logic [ACC_W-1:0]           o_acc,
    output logic                       o_fire,
    output logic [mdsg_pkg::POS_W-1:0] o_pos,
    output logic [mdsg_pkg::POS_W-1:0] o_galvo
);
    logic [ACC_W-1:0] sum;

    always_comb begin
        sum    = i_acc + ACC_W'(i_steps);
        // positive: sign clear and not zero
        o_fire = !sum[ACC_W-1] && (|sum);
        o_acc  = o_fire ? (sum - ACC_W'(i_total)) : sum;
        if (o_fire) begin
            o_pos   = i_dir ? (i_pos - 32'd1) : (i_pos + 32'd1);
            o_galvo = i_dir ? (i_galvo - 32'd1) : (i_galvo + 32'd1);
        end else begin
            o_pos   = i_pos;
            o_galvo = i_galvo;
        end
    end
endmodule

>>> rtl/multi_axis_dda_step_generator.sv
`timescale 1ns / 1ps
// channel   dir  handshake        beat
// i_in      in   valid/ready      op, axis steps, event total, dirs, loops, endstops, set pos
// o_out     out  valid/ready      step pulses, dirs, four positions, galvo x/y, status flags
// i_cfg     in   we only          endstop_check enable
//
// load, set position, idle tick or endstop stop: one beat, accept state then output state.
// active tick: accept, then per sub-step each axis in turn on the shared
// axis adder, followed by one output beat for that sub-step.
// one item at a time; a stalled output holds the sequencer in its output state.
// synchronous active-low reset; endstop checking is enabled after reset.
module multi_axis_dda_step_generator #(
    parameter int STEP_COUNT_BITS = mdsg_pkg::STEP_COUNT_BITS_DEF,
    parameter int MAX_SUBSTEPS    = mdsg_pkg::MAX_SUBSTEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mdsg_in_if.sink      i_in,
    mdsg_out_if.source   o_out,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata
);
    localparam int ACC_W  = STEP_COUNT_BITS + 2;
    localparam int LOOP_W = (MAX_SUBSTEPS > 1) ? $clog2(MAX_SUBSTEPS) : 1;
    localparam int AXES   = mdsg_pkg::AXES;
    localparam int AXIS_W = mdsg_pkg::AXIS_W;
    localparam int POS_W  = mdsg_pkg::POS_W;

    typedef enum logic [1:0] {S_IDLE, S_AXIS, S_EMIT} t_state;

    t_state                     r_state;
    logic                       r_endstop_chk;
    logic                       r_active;
    logic [STEP_COUNT_BITS-1:0] r_steps [AXES];
    logic [STEP_COUNT_BITS-1:0] r_total;
    logic [3:0]                 r_dirs;
    logic [ACC_W-1:0]           r_acc [AXES];
    logic [STEP_COUNT_BITS-1:0] r_ev;
    logic [POS_W-1:0]           r_pos [AXES];
    logic [POS_W-1:0]           r_galvo [2];
    logic                       r_prev_min;
    logic                       r_prev_max;

    logic [AXIS_W-1:0]          r_axis;
    logic [LOOP_W-1:0]          r_sub;
    logic [LOOP_W-1:0]          r_last_sub;
    logic [3:0]                 r_pulses;
    logic                       r_e_hit;
    logic                       r_e_done;
    logic                       r_e_idle;
    logic                       r_e_last;

    logic                       r_out_valid;
    logic [3:0]                 r_o_pulses;
    logic [3:0]                 r_o_dirs;
    logic [POS_W-1:0]           r_o_pos [AXES];
    logic [mdsg_pkg::GALVO_OUT_W-1:0] r_o_galvo [2];
    logic                       r_o_hit;
    logic                       r_o_done;
    logic                       r_o_idle;
    logic                       r_o_last;

    logic [ACC_W-1:0]           alu_acc;
    logic                       alu_fire;
    logic [POS_W-1:0]           alu_pos;
    logic [POS_W-1:0]           alu_galvo;

    logic                       es_neg;
    logic                       es_sample;
    logic                       es_prev;
    logic                       es_hit;
    logic                       tick_run;
    logic                       tick_stop;
    logic [3:0]                 lp;
    logic [STEP_COUNT_BITS-1:0] n_ev;
    logic                       n_done;

    mdsg_axis_alu #(
        .STEP_W (STEP_COUNT_BITS),
        .ACC_W  (ACC_W)
    ) u_alu (
        .i_acc   (r_acc[r_axis]),
        .i_steps (r_steps[r_axis]),
        .i_total (r_total),
        .i_dir   (r_dirs[r_axis]),
        .i_pos   (r_pos[r_axis]),
        .i_galvo (r_galvo[r_axis[0]]),
        .o_acc   (alu_acc),
        .o_fire  (alu_fire),
        .o_pos   (alu_pos),
        .o_galvo (alu_galvo)
    );

    always_comb begin
        // only the endstop facing the z direction is looked at
        es_neg    = r_dirs[mdsg_pkg::AXIS_Z];
        es_sample = es_neg ? i_in.z_min_active : i_in.z_max_active;
        es_prev   = es_neg ? r_prev_min : r_prev_max;
        es_hit    = r_endstop_chk && es_sample && es_prev && (|r_steps[mdsg_pkg::AXIS_Z]);

        tick_run  = (i_in.op == mdsg_pkg::OP_TICK) && r_active && !es_hit;
        tick_stop = (i_in.op == mdsg_pkg::OP_TICK) && r_active && es_hit;

        lp = {1'b0, i_in.loops_per_tick};
        if (lp == 4'd0) begin
            lp = 4'd1;
        end
        if (lp > 4'(MAX_SUBSTEPS)) begin
            lp = 4'(MAX_SUBSTEPS);
        end

        n_ev   = r_ev + STEP_COUNT_BITS'(1);
        n_done = (n_ev >= r_total);
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_endstop_chk <= 1'b1;
            r_active      <= 1'b0;
            r_total       <= '0;
            r_dirs        <= '0;
            r_ev          <= '0;
            r_prev_min    <= 1'b0;
            r_prev_max    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_axis        <= '0;
            r_sub         <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_steps[i] <= '0;
                r_acc[i]   <= '0;
                r_pos[i]   <= '0;
            end
            r_galvo[0] <= '0;
            r_galvo[1] <= '0;
        end else begin
            if (i_cfg_we) begin
                r_endstop_chk <= i_cfg_wdata;
            end
            if (r_out_valid && o_out.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_pulses   <= '0;
                        r_e_hit    <= tick_stop;
                        r_e_done   <= tick_stop;
                        r_e_last   <= 1'b1;
                        // a refused load reports idle, an accepted one does not
                        r_e_idle   <= (i_in.op == mdsg_pkg::OP_LOAD) ? r_active
                                                                     : (!r_active || tick_stop);
                        r_axis     <= '0;
                        r_sub      <= '0;
                        r_last_sub <= LOOP_W'(lp - 4'd1);
                        r_state    <= tick_run ? S_AXIS : S_EMIT;
                        case (i_in.op)
                            mdsg_pkg::OP_LOAD: begin
                                if (!r_active) begin
                                    r_steps[0] <= i_in.steps_x;
                                    r_steps[1] <= i_in.steps_y;
                                    r_steps[2] <= i_in.steps_z;
                                    r_steps[3] <= i_in.steps_aux;
                                    r_total    <= i_in.event_total;
                                    r_dirs     <= i_in.dir_mask;
                                    for (int i = 0; i < AXES; i++) begin
                                        r_acc[i] <= ACC_W'(0) - ACC_W'(i_in.event_total >> 1);
                                    end
                                    r_ev     <= '0;
                                    r_active <= 1'b1;
                                end
                            end
                            mdsg_pkg::OP_SET_POS: begin
                                r_pos[i_in.axis_index] <= i_in.position_value;
                            end
                            mdsg_pkg::OP_TICK: begin
                                if (r_active) begin
                                    if (r_endstop_chk) begin
                                        if (es_neg) begin
                                            r_prev_min <= es_sample;
                                        end else begin
                                            r_prev_max <= es_sample;
                                        end
                                    end
                                    if (es_hit) begin
                                        r_active <= 1'b0;
                                        r_ev     <= r_total;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_AXIS: begin
                    r_acc[r_axis] <= alu_acc;
                    r_pos[r_axis] <= alu_pos;
                    if (r_axis < AXIS_W'(2)) begin
                        r_galvo[r_axis[0]] <= alu_galvo;
                    end
                    if (alu_fire) begin
                        r_pulses[r_axis] <= 1'b1;
                    end
                    if (r_axis == AXIS_W'(AXES - 1)) begin
                        r_ev     <= n_ev;
                        r_e_done <= n_done;
                        r_e_idle <= n_done;
                        r_e_last <= n_done || (r_sub == r_last_sub);
                        if (n_done) begin
                            r_active <= 1'b0;
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_axis <= r_axis + AXIS_W'(1);
                    end
                end

                S_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_o_pulses   <= r_pulses;
                        r_o_dirs     <= r_dirs;
                        for (int i = 0; i < AXES; i++) begin
                            r_o_pos[i] <= r_pos[i];
                        end
                        r_o_galvo[0] <= mdsg_pkg::galvo_clamp(r_galvo[0]);
                        r_o_galvo[1] <= mdsg_pkg::galvo_clamp(r_galvo[1]);
                        r_o_hit      <= r_e_hit;
                        r_o_done     <= r_e_done;
                        r_o_idle     <= r_e_idle;
                        r_o_last     <= r_e_last;
                        if (r_e_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sub    <= r_sub + LOOP_W'(1);
                            r_axis   <= '0;
                            r_pulses <= '0;
                            r_state  <= S_AXIS;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.step_pulses   = r_o_pulses;
    assign o_out.dir_out       = r_o_dirs;
    assign o_out.pos_x         = r_o_pos[0];
    assign o_out.pos_y         = r_o_pos[1];
    assign o_out.pos_z         = r_o_pos[2];
    assign o_out.pos_fourth    = r_o_pos[3];
    assign o_out.galvo_x       = r_o_galvo[mdsg_pkg::AXIS_X];
    assign o_out.galvo_y       = r_o_galvo[mdsg_pkg::AXIS_Y];
    assign o_out.z_endstop_hit = r_o_hit;
    assign o_out.block_done    = r_o_done;
    assign o_out.idle          = r_o_idle;
    assign o_out.last          = r_o_last;
endmodule
